/* design/yuvcrop_pkg.sv */
// Shared types and constants for the YUV420p planar window crop unit.
`timescale 1ns / 1ps
`default_nettype none
package yuvcrop_pkg;

   localparam int MAX_DIM   = 8192;
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int CNT_W     = $clog2(MAX_DIM);
   localparam int CSR_W     = 14;
   localparam int REG_IDX_W = 3;
   localparam int PIX_W     = 8;
   localparam int CMP_W     = (CSR_W > DIM_W) ? CSR_W : DIM_W;

   localparam logic [CSR_W-1:0] RST_SOURCE_WIDTH  = CSR_W'(3264);
   localparam logic [CSR_W-1:0] RST_SOURCE_HEIGHT = CSR_W'(2448);
   localparam logic [CSR_W-1:0] RST_CROP_WIDTH    = CSR_W'(1280);
   localparam logic [CSR_W-1:0] RST_CROP_HEIGHT   = CSR_W'(720);
   localparam logic             RST_ANCHOR_BOTTOM = 1'b1;

   typedef enum logic [1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SOURCE_WIDTH  = 3'd0,
      REG_SOURCE_HEIGHT = 3'd1,
      REG_CROP_WIDTH    = 3'd2,
      REG_CROP_HEIGHT   = 3'd3,
      REG_ANCHOR_BOTTOM = 3'd4
   } reg_index_type;

   // bounds of one plane and of its kept window
   typedef struct packed {
      logic [DIM_W-1:0] plane_w;
      logic [DIM_W-1:0] plane_h;
      logic [DIM_W-1:0] win_w;
      logic [DIM_W-1:0] row_lo;
      logic [DIM_W-1:0] row_hi;
   } plane_geom_type;

   typedef struct packed {
      plane_geom_type luma;
      plane_geom_type chroma;
   } geom_type;

   typedef struct packed {
      logic      keep;
      logic      last;
      plane_type plane;
   } decision_type;

endpackage
`default_nettype wire

/* design/yuvcrop_if.sv */
// Handshake channel interfaces: sample input, kept sample output, register write.
`timescale 1ns / 1ps
`default_nettype none
interface yuvcrop_req_if import yuvcrop_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface yuvcrop_rsp_if import yuvcrop_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic [1:0]       plane_id;
   logic             frame_last;

   modport source (output valid, output pixel_out, output plane_id, output frame_last,
                   input ready);
   modport sink   (input valid, input pixel_out, input plane_id, input frame_last,
                   output ready);
endinterface

interface yuvcrop_csr_if import yuvcrop_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [REG_IDX_W-1:0] index;
   logic [CSR_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/yuvcrop_geom.sv */
// Configuration registers and registered crop geometry for luma and chroma planes.
`timescale 1ns / 1ps
`default_nettype none
module yuvcrop_geom import yuvcrop_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   yuvcrop_csr_if.sink  csr_chan,
   output geom_type     geom,
   output logic         settling
);

   logic [CSR_W-1:0] source_width_ff,  source_width_in;
   logic [CSR_W-1:0] source_height_ff, source_height_in;
   logic [CSR_W-1:0] crop_width_ff,    crop_width_in;
   logic [CSR_W-1:0] crop_height_ff,   crop_height_in;
   logic             anchor_bottom_ff, anchor_bottom_in;
   logic             settle_ff,        settle_in;
   geom_type         geom_ff,          geom_in;

   logic [DIM_W-1:0] sw, sh, cw, ch;
   logic             csr_xfer;

   // clamp to [2, MAX_DIM] and round down to even
   function automatic logic [DIM_W-1:0] clamp_source(input logic [CSR_W-1:0] v);
      logic [CMP_W-1:0] ve;
      logic [DIM_W-1:0] r;
      ve = CMP_W'(v);
      if (ve < CMP_W'(2))
         r = DIM_W'(2);
      else if (ve > CMP_W'(MAX_DIM))
         r = DIM_W'(MAX_DIM);
      else
         r = DIM_W'(ve);
      return {r[DIM_W-1:1], 1'b0};
   endfunction

   // clamp to [2, source dimension]
   function automatic logic [DIM_W-1:0] clamp_crop(input logic [CSR_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
      logic [CMP_W-1:0] ve;
      logic [DIM_W-1:0] r;
      ve = CMP_W'(v);
      if (ve < CMP_W'(2))
         r = DIM_W'(2);
      else if (ve > CMP_W'(hi))
         r = hi;
      else
         r = DIM_W'(ve);
      return r;
   endfunction

   assign csr_chan.ready = 1'b1;
   assign csr_xfer       = csr_chan.valid & csr_chan.ready;

   always_comb begin
      source_width_in  = source_width_ff;
      source_height_in = source_height_ff;
      crop_width_in    = crop_width_ff;
      crop_height_in   = crop_height_ff;
      anchor_bottom_in = anchor_bottom_ff;
      if (csr_xfer) begin
         case (csr_chan.index)
            REG_SOURCE_WIDTH:  source_width_in  = csr_chan.data;
            REG_SOURCE_HEIGHT: source_height_in = csr_chan.data;
            REG_CROP_WIDTH:    crop_width_in    = csr_chan.data;
            REG_CROP_HEIGHT:   crop_height_in   = csr_chan.data;
            REG_ANCHOR_BOTTOM: anchor_bottom_in = csr_chan.data[0];
            default: ;
         endcase
      end
      // hold off samples while the geometry reloads
      settle_in = csr_xfer;
   end

   always_comb begin
      sw = clamp_source(source_width_ff);
      sh = clamp_source(source_height_ff);
      cw = clamp_crop(crop_width_ff, sw);
      ch = clamp_crop(crop_height_ff, sh);

      geom_in.luma.plane_w   = sw;
      geom_in.luma.plane_h   = sh;
      geom_in.luma.win_w     = cw;
      geom_in.chroma.plane_w = sw >> 1;
      geom_in.chroma.plane_h = sh >> 1;
      geom_in.chroma.win_w   = cw >> 1;
      if (anchor_bottom_ff) begin
         geom_in.luma.row_lo   = sh - ch;
         geom_in.luma.row_hi   = sh;
         geom_in.chroma.row_lo = (sh - ch) >> 1;
         geom_in.chroma.row_hi = sh >> 1;
      end else begin
         geom_in.luma.row_lo   = '0;
         geom_in.luma.row_hi   = ch;
         geom_in.chroma.row_lo = '0;
         geom_in.chroma.row_hi = ch >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= RST_SOURCE_WIDTH;
         source_height_ff <= RST_SOURCE_HEIGHT;
         crop_width_ff    <= RST_CROP_WIDTH;
         crop_height_ff   <= RST_CROP_HEIGHT;
         anchor_bottom_ff <= RST_ANCHOR_BOTTOM;
         settle_ff        <= 1'b1;
      end else begin
         source_width_ff  <= source_width_in;
         source_height_ff <= source_height_in;
         crop_width_ff    <= crop_width_in;
         crop_height_ff   <= crop_height_in;
         anchor_bottom_ff <= anchor_bottom_in;
         settle_ff        <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom     = geom_ff;
   assign settling = settle_ff;

endmodule
`default_nettype wire

/* design/yuvcrop_track.sv */
// Plane, row and column tracker with the keep and frame-end decision per sample.
`timescale 1ns / 1ps
`default_nettype none
module yuvcrop_track import yuvcrop_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire geom_type geom,
   input  wire logic     advance,
   output decision_type  decision
);

   plane_type        plane_ff, plane_in;
   logic [CNT_W-1:0] row_ff,   row_in;
   logic [CNT_W-1:0] col_ff,   col_in;

   plane_geom_type   g_cur, g_eff;
   logic             col_wrap, plane_wrap;
   logic [DIM_W-1:0] row_a, row_e, col_e, row_nx, col_nx;
   plane_type        plane_e;

   function automatic plane_type next_plane(input plane_type p);
      plane_type r;
      case (p)
         PLANE_Y: r = PLANE_U;
         PLANE_U: r = PLANE_V;
         default: r = PLANE_Y;
      endcase
      return r;
   endfunction

   always_comb begin
      g_cur = (plane_ff == PLANE_Y) ? geom.luma : geom.chroma;

      // wrap a position that a geometry change left outside the plane
      col_wrap   = DIM_W'(col_ff) >= g_cur.plane_w;
      row_a      = col_wrap ? DIM_W'(row_ff) + DIM_W'(1) : DIM_W'(row_ff);
      plane_wrap = row_a >= g_cur.plane_h;
      plane_e    = plane_wrap ? next_plane(plane_ff) : plane_ff;
      row_e      = plane_wrap ? '0 : row_a;
      col_e      = (col_wrap || plane_wrap) ? '0 : DIM_W'(col_ff);

      g_eff = (plane_e == PLANE_Y) ? geom.luma : geom.chroma;

      decision.plane = plane_e;
      decision.keep  = (col_e < g_eff.win_w) && (row_e >= g_eff.row_lo) &&
                       (row_e < g_eff.row_hi);
      decision.last  = decision.keep && (plane_e == PLANE_V) &&
                       (row_e + DIM_W'(1) == g_eff.row_hi) &&
                       (col_e + DIM_W'(1) == g_eff.win_w);

      // advance to the next raster position
      col_nx   = col_e + DIM_W'(1);
      row_nx   = row_e + DIM_W'(1);
      plane_in = plane_e;
      row_in   = CNT_W'(row_e);
      col_in   = CNT_W'(col_nx);
      if (col_nx >= g_eff.plane_w) begin
         col_in = '0;
         row_in = CNT_W'(row_nx);
         if (row_nx >= g_eff.plane_h) begin
            row_in   = '0;
            plane_in = next_plane(plane_e);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= PLANE_Y;
         row_ff   <= '0;
         col_ff   <= '0;
      end else if (advance) begin
         plane_ff <= plane_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_hold_between_transfers: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (plane_ff == $past(plane_ff) && row_ff == $past(row_ff) &&
                    col_ff == $past(col_ff)))
      else $error("position moved without a sample transfer");

   a_plane_legal: assert property (@(posedge clock) disable iff (reset)
      (plane_ff == PLANE_Y) || (plane_ff == PLANE_U) || (plane_ff == PLANE_V))
      else $error("plane counter left the Y, U, V range");

   a_last_only_on_kept_v: assert property (@(posedge clock) disable iff (reset)
      decision.last |-> (decision.keep && decision.plane == PLANE_V))
      else $error("frame end flagged on a dropped or non-V sample");
`endif

endmodule
`default_nettype wire

/* design/yuv420p_planar_window_crop_unit.sv */
// Top level of the YUV420p planar window crop unit.
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte of a planar YUV420p frame per transfer (Y plane, then U, then V, raster
// order) and forwards only the bytes inside a left-anchored window at the top or bottom of
// the frame, tagged with their plane and with a flag on the last kept byte of the frame.
// One sample is taken every cycle unless the output is held or the geometry reloads; a
// kept sample appears on the output in the cycle after its input transfer. The rate is
// set by the plane/row/column counter update, which advances once per sample. The output
// register frees itself in the same cycle it is taken, so input flows on while the output
// is being drained. After every register write the input stalls while the clamped window
// geometry is reloaded; the same holds after reset.
module yuv420p_planar_window_crop_unit import yuvcrop_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   yuvcrop_req_if.sink    req_chan,
   yuvcrop_rsp_if.source  rsp_chan,
   yuvcrop_csr_if.sink    csr_chan
);

   geom_type         geom;
   logic             settling;
   decision_type     decision;
   logic             out_free, req_xfer;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] pixel_ff;
   plane_type        plane_ff;
   logic             last_ff;

   yuvcrop_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .geom     (geom),
      .settling (settling)
   );

   yuvcrop_track u_track (
      .clock    (clock),
      .reset    (reset),
      .geom     (geom),
      .advance  (req_xfer),
      .decision (decision)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = out_free && !settling;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (req_xfer) begin
         rsp_valid_in = decision.keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && decision.keep) begin
         pixel_ff <= req_chan.pixel_in;
         plane_ff <= decision.plane;
         last_ff  <= decision.last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pixel_out  = pixel_ff;
   assign rsp_chan.plane_id   = plane_ff;
   assign rsp_chan.frame_last = last_ff;

`ifndef NO_ASSERTIONS
   a_stall_after_write: assert property (@(posedge clock) disable iff (reset)
      (csr_chan.valid && csr_chan.ready) |=> !req_chan.ready)
      else $error("sample taken before the geometry reloaded");

   a_output_from_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !$past(rsp_chan.valid)) |-> $past(req_xfer))
      else $error("output appeared without an input transfer");

   a_last_is_v_plane: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_last) |-> (rsp_chan.plane_id == PLANE_V))
      else $error("frame end flagged outside the V plane");
`endif

endmodule
`default_nettype wire
